[rtl/core/ata_tfb_pkg.sv]
// Shared types, constants and codes for the ATA task-file builder.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package ata_tfb_pkg;

   // Field widths
   localparam int ADDR_W    = 32;
   localparam int COUNT_W   = 8;
   localparam int BYTE_W    = 8;
   localparam int LBA28_W   = 28;
   localparam int HEAD_W    = 4;
   localparam int CYL_W     = 16;
   localparam int SECTOR_W  = 6;

   // Divide by 63 through a reciprocal: floor(x * RECIP / 2^SHIFT) == x / 63
   // holds for every x below 2^28 (error term 47 * 2^28 < 2^34).
   localparam int CHS_SHIFT = 34;
   localparam int RECIP_W   = 29;
   localparam logic [RECIP_W-1:0] CHS_RECIP = 29'd272696337;
   localparam int PROD_W    = LBA28_W + RECIP_W;
   localparam int QUOT_W    = PROD_W - CHS_SHIFT;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_DMA_ENABLE = 1'b0;

   // Device/head register bases
   localparam logic [BYTE_W-1:0] DEVSEL_CHS = 8'hA0;
   localparam logic [BYTE_W-1:0] DEVSEL_LBA = 8'hE0;

   // ATA opcodes
   localparam logic [BYTE_W-1:0] CMD_READ_PIO      = 8'h20;
   localparam logic [BYTE_W-1:0] CMD_WRITE_PIO     = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_READ_DMA      = 8'hC8;
   localparam logic [BYTE_W-1:0] CMD_WRITE_DMA     = 8'hCA;
   localparam logic [BYTE_W-1:0] CMD_READ_PIO_EXT  = 8'h24;
   localparam logic [BYTE_W-1:0] CMD_WRITE_PIO_EXT = 8'h34;
   localparam logic [BYTE_W-1:0] CMD_READ_DMA_EXT  = 8'h25;
   localparam logic [BYTE_W-1:0] CMD_WRITE_DMA_EXT = 8'h35;

   typedef enum logic [1:0] {
      MODE_CHS   = 2'd0,
      MODE_LBA28 = 2'd1,
      MODE_LBA48 = 2'd2
   } address_mode_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  block_address;
      logic               is_write;
      logic               drive_select;
      logic [COUNT_W-1:0] sector_count;
      logic               lba_capable;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] command_code;
      logic [BYTE_W-1:0] device_select;
      logic [BYTE_W-1:0] count_value;
      logic [BYTE_W-1:0] address_byte0;
      logic [BYTE_W-1:0] address_byte1;
      logic [BYTE_W-1:0] address_byte2;
      logic [BYTE_W-1:0] address_byte3;
      address_mode_type  address_mode;
   } rsp_word_type;

   typedef struct packed {
      logic [CYL_W-1:0]    cylinder;
      logic [HEAD_W-1:0]   head;
      logic [SECTOR_W-1:0] sector;
   } chs_type;

   typedef struct packed {
      logic dma_enable;
   } cfg_type;

endpackage

`default_nettype wire

[rtl/core/ata_tfb_if.sv]
// Valid/ready channel interfaces for requests and task-file results.
// Depends on ata_tfb_pkg.
`default_nettype none

interface ata_tfb_req_if;
   import ata_tfb_pkg::*;

   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  block_address;
   logic               is_write;
   logic               drive_select;
   logic [COUNT_W-1:0] sector_count;
   logic               lba_capable;

   modport source (output valid, block_address, is_write, drive_select, sector_count,
                   lba_capable, input ready);
   modport sink   (input valid, block_address, is_write, drive_select, sector_count,
                   lba_capable, output ready);
endinterface

interface ata_tfb_rsp_if;
   import ata_tfb_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] command_code;
   logic [BYTE_W-1:0] device_select;
   logic [BYTE_W-1:0] count_value;
   logic [BYTE_W-1:0] address_byte0;
   logic [BYTE_W-1:0] address_byte1;
   logic [BYTE_W-1:0] address_byte2;
   logic [BYTE_W-1:0] address_byte3;
   address_mode_type  address_mode;

   modport source (output valid, command_code, device_select, count_value, address_byte0,
                   address_byte1, address_byte2, address_byte3, address_mode,
                   input ready);
   modport sink   (input valid, command_code, device_select, count_value, address_byte0,
                   address_byte1, address_byte2, address_byte3, address_mode,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/ata_tfb_csr.sv]
// APB-style register block holding the DMA enable bit.
// Depends on ata_tfb_pkg.
`default_nettype none

module ata_tfb_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [ata_tfb_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ata_tfb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [ata_tfb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready,
   output ata_tfb_pkg::cfg_type                  cfg
);
   import ata_tfb_pkg::*;

   logic                 dma_enable_ff;
   logic                 dma_enable_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_strobe;

   assign reg_idx   = paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      dma_enable_in = dma_enable_ff;
      if (wr_strobe && (reg_idx == CSR_IDX_DMA_ENABLE)) begin
         dma_enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dma_enable_ff <= 1'b0;
      end else begin
         dma_enable_ff <= dma_enable_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == CSR_IDX_DMA_ENABLE) begin
         prdata = {{(CSR_DATA_W-1){1'b0}}, dma_enable_ff};
      end
   end

   assign cfg.dma_enable = dma_enable_ff;

endmodule

`default_nettype wire

[rtl/core/ata_tfb_chs_map.sv]
// Maps a 28-bit block address to cylinder/head/sector (63 sectors, 16 heads).
// Depends on ata_tfb_pkg.
`default_nettype none

module ata_tfb_chs_map (
   input  wire logic [ata_tfb_pkg::LBA28_W-1:0] lba,
   output ata_tfb_pkg::chs_type                 chs
);
   import ata_tfb_pkg::*;

   logic [PROD_W-1:0]   product;
   logic [QUOT_W-1:0]   track;
   logic [SECTOR_W-1:0] remainder;

   // track = lba / 63 by reciprocal multiply
   assign product = PROD_W'(lba) * PROD_W'(CHS_RECIP);
   assign track   = product[PROD_W-1:CHS_SHIFT];

   // lba - 63*track == lba + track (mod 64), and the remainder is below 63
   assign remainder = lba[SECTOR_W-1:0] + track[SECTOR_W-1:0];

   assign chs.sector   = remainder + SECTOR_W'(1);
   assign chs.head     = track[HEAD_W-1:0];
   assign chs.cylinder = track[HEAD_W +: CYL_W];

endmodule

`default_nettype wire

[rtl/core/ata_tfb_encode.sv]
// Picks the addressing mode and forms the task-file register values.
// Depends on ata_tfb_pkg.
`default_nettype none

module ata_tfb_encode (
   input  ata_tfb_pkg::req_word_type req,
   input  ata_tfb_pkg::chs_type      chs,
   input  ata_tfb_pkg::cfg_type      cfg,
   output ata_tfb_pkg::rsp_word_type rsp
);
   import ata_tfb_pkg::*;

   logic              is_lba48;
   logic [HEAD_W-1:0] head;
   logic [BYTE_W-1:0] sel_base;

   assign is_lba48 = |req.block_address[ADDR_W-1:LBA28_W];

   always_comb begin
      rsp.count_value   = req.sector_count;
      rsp.address_byte0 = req.block_address[7:0];
      rsp.address_byte1 = req.block_address[15:8];
      rsp.address_byte2 = req.block_address[23:16];
      rsp.address_byte3 = '0;
      head              = '0;
      sel_base          = DEVSEL_LBA;
      if (is_lba48) begin
         rsp.address_mode  = MODE_LBA48;
         rsp.address_byte3 = req.block_address[31:24];
      end else if (req.lba_capable) begin
         rsp.address_mode  = MODE_LBA28;
         head              = req.block_address[LBA28_W-1:LBA28_W-HEAD_W];
      end else begin
         rsp.address_mode  = MODE_CHS;
         rsp.address_byte0 = BYTE_W'(chs.sector);
         rsp.address_byte1 = chs.cylinder[7:0];
         rsp.address_byte2 = chs.cylinder[15:8];
         head              = chs.head;
         sel_base          = DEVSEL_CHS;
      end
      rsp.device_select = sel_base | {3'b000, req.drive_select, 4'b0000}
                          | {4'b0000, head};
   end

   always_comb begin
      case ({is_lba48, cfg.dma_enable, req.is_write})
         3'b000:  rsp.command_code = CMD_READ_PIO;
         3'b001:  rsp.command_code = CMD_WRITE_PIO;
         3'b010:  rsp.command_code = CMD_READ_DMA;
         3'b011:  rsp.command_code = CMD_WRITE_DMA;
         3'b100:  rsp.command_code = CMD_READ_PIO_EXT;
         3'b101:  rsp.command_code = CMD_WRITE_PIO_EXT;
         3'b110:  rsp.command_code = CMD_READ_DMA_EXT;
         default: rsp.command_code = CMD_WRITE_DMA_EXT;
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/ata_task_file_builder.sv]
// ATA task-file builder: top level with input and result registers.
// Depends on ata_tfb_pkg, ata_tfb_if, ata_tfb_csr, ata_tfb_chs_map, ata_tfb_encode.
//
// Usage:
//   req_chan  (sink)   one word per sector request: block address, direction,
//                      drive, sector count and the device's LBA capability.
//   rsp_chan  (source) one word per request: opcode, device/head, count,
//                      four address bytes and the address mode (CHS/LBA28/LBA48).
//   APB port           register 0 (byte address 0) = dma_enable, bit 0.
//                      Write it only while no request is in flight.
//   An accepted request passes through the input register and then the
//   result register before its result shows (two registers in all).
//   Throughput: one word per cycle while rsp_chan.ready stays high; the divide
//   by 63 for CHS is a single reciprocal multiply between the two registers.
//   Reset (synchronous, active high) empties both registers and clears
//   dma_enable; req_chan.ready stays low while reset is high and comes up
//   as soon as reset drops.
//   When the receiver stalls, the result register holds its word, the input
//   register fills with one more word, and ready then drops until rsp_chan
//   drains. No word is lost or repeated.
`default_nettype none

module ata_task_file_builder (
   input  wire logic                               clock,
   input  wire logic                               reset,
   ata_tfb_req_if.sink                             req_chan,
   ata_tfb_rsp_if.source                           rsp_chan,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ata_tfb_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [ata_tfb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [ata_tfb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                    pready
);
   import ata_tfb_pkg::*;

   cfg_type      cfg;
   chs_type      chs;
   req_word_type req_word;
   rsp_word_type rsp_word;

   // Input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;

   // Result register
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;

   logic         req_accept;
   logic         advance;

   ata_tfb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Pack the incoming word
   assign req_word.block_address = req_chan.block_address;
   assign req_word.is_write      = req_chan.is_write;
   assign req_word.drive_select  = req_chan.drive_select;
   assign req_word.sector_count  = req_chan.sector_count;
   assign req_word.lba_capable   = req_chan.lba_capable;

   // Advance into the result register whenever it is empty or being drained;
   // hold ready low during reset so no word is taken and then dropped
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !reset && (!in_valid_ff || advance);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on accept / advance, otherwise hold
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
      if (advance && in_valid_ff) begin
         out_word_ff <= rsp_word;
      end
   end

   // Single pass from the input register to the result register
   ata_tfb_chs_map u_chs_map (
      .lba (in_word_ff.block_address[LBA28_W-1:0]),
      .chs (chs)
   );

   ata_tfb_encode u_encode (
      .req (in_word_ff),
      .chs (chs),
      .cfg (cfg),
      .rsp (rsp_word)
   );

   // Drive the result channel
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.command_code  = out_word_ff.command_code;
   assign rsp_chan.device_select = out_word_ff.device_select;
   assign rsp_chan.count_value   = out_word_ff.count_value;
   assign rsp_chan.address_byte0 = out_word_ff.address_byte0;
   assign rsp_chan.address_byte1 = out_word_ff.address_byte1;
   assign rsp_chan.address_byte2 = out_word_ff.address_byte2;
   assign rsp_chan.address_byte3 = out_word_ff.address_byte3;
   assign rsp_chan.address_mode  = out_word_ff.address_mode;

endmodule

`default_nettype wire

[rtl/core/ata_tfb_checker.sv]
// Port-level checks for the ATA task-file builder, bound to the top level.
// Depends on ata_tfb_pkg and ata_task_file_builder.
`default_nettype none

module ata_tfb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ata_tfb_pkg::BYTE_W-1:0] device_select,
   input wire logic [ata_tfb_pkg::BYTE_W-1:0] address_byte0,
   input wire logic [ata_tfb_pkg::BYTE_W-1:0] address_byte3,
   input wire logic [1:0]                    address_mode
);
   import ata_tfb_pkg::*;

   // A stalled result stays valid and holds address_byte0 and device_select
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(address_byte0)
                                 && $stable(device_select))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // LBA48 carries a nonzero top byte and a zero head; other modes zero it
   a_lba48_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (address_mode == MODE_LBA48)
         ? (address_byte3 != '0 && device_select[3:0] == '0
            && device_select[7:4] != DEVSEL_CHS[7:4])
         : (address_byte3 == '0))
      else $error("inconsistent LBA48 fields");

   // CHS sector number lies in 1..63
   a_chs_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && address_mode == MODE_CHS |->
         address_byte0 != '0 && address_byte0[7:6] == 2'b00)
      else $error("CHS sector out of range");

endmodule

bind ata_task_file_builder ata_tfb_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .device_select (rsp_chan.device_select),
   .address_byte0 (rsp_chan.address_byte0),
   .address_byte3 (rsp_chan.address_byte3),
   .address_mode  (rsp_chan.address_mode)
);

`default_nettype wire

[dv/ata_task_file_builder_tb.sv]
// Self-checking testbench for the ATA task-file builder: a directed table, then random
// requests under four idle patterns, each word checked against its table entry or a built-in predictor.
// Depends on ata_tfb_pkg, ata_tfb_if and the ata_task_file_builder RTL.
`timescale 1ns / 100ps

module ata_task_file_builder_tb;
   import ata_tfb_pkg::*;

   // Geometry and limits of the address mapping
   localparam logic [ADDR_W-1:0] LBA48_FLOOR        = 32'h1000_0000;
   localparam logic [ADDR_W-1:0] SECTORS_PER_TRACK  = 32'd63;
   localparam logic [ADDR_W-1:0] HEADS_PER_CYLINDER = 32'd16;

   // Register map: dma_enable at index 0; index 1 is unused and must ignore writes
   localparam logic [CSR_ADDR_W-1:0] DMA_ADDR   = {CSR_IDX_DMA_ENABLE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'b100;

   localparam int PHASE_ITEMS    = 100;
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      bit           dma;
      req_word_type req;
      bit           has_fixed;
      rsp_word_type tf;
   } stim_row_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   ata_tfb_req_if req_if ();
   ata_tfb_rsp_if rsp_if ();

   ata_task_file_builder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Testbench copy of the configuration and the store of pending task files
   logic         dma_cfg;
   rsp_word_type task_file_queue[$];
   rsp_word_type exp_tf;
   stim_row_type stim_rows[$];

   // Fixed expectation for the word currently offered, if the table row has one
   bit           cur_fixed;
   rsp_word_type cur_tf;

   int mismatch_count;
   int results_seen;
   int mode_count[3];
   int dma_words[2];
   int quiet_cycles;
   int sender_idle_pct;
   int receiver_stall_pct;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Expected task file for one request under the given DMA setting
   function automatic rsp_word_type build_task_file(req_word_type r, logic dma);
      rsp_word_type     tf;
      address_mode_type mode;
      logic [ADDR_W-1:0] track;
      logic [ADDR_W-1:0] cyl_full;
      logic [ADDR_W-1:0] sector;
      logic [HEAD_W-1:0] head;
      logic [BYTE_W-1:0] b0, b1, b2, b3;

      if (r.block_address >= LBA48_FLOOR) begin
         mode = MODE_LBA48;
         {b3, b2, b1, b0} = r.block_address;
         head = '0;
      end else if (r.lba_capable) begin
         mode = MODE_LBA28;
         {b2, b1, b0} = r.block_address[23:0];
         b3   = '0;
         head = r.block_address[27:24];
      end else begin
         // CHS: cylinder keeps only its low 16 bits, so large addresses wrap
         mode     = MODE_CHS;
         track    = r.block_address / SECTORS_PER_TRACK;
         sector   = r.block_address % SECTORS_PER_TRACK + 32'd1;
         cyl_full = track / HEADS_PER_CYLINDER;
         b0       = sector[7:0];
         b1       = cyl_full[7:0];
         b2       = cyl_full[15:8];
         b3       = '0;
         head     = track[3:0];
      end

      tf.address_mode  = mode;
      tf.count_value   = r.sector_count;
      tf.address_byte0 = b0;
      tf.address_byte1 = b1;
      tf.address_byte2 = b2;
      tf.address_byte3 = b3;
      tf.device_select = ((mode == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA)
                         | {3'b000, r.drive_select, head};
      if (mode == MODE_LBA48)
         tf.command_code = dma ? (r.is_write ? CMD_WRITE_DMA_EXT : CMD_READ_DMA_EXT)
                               : (r.is_write ? CMD_WRITE_PIO_EXT : CMD_READ_PIO_EXT);
      else
         tf.command_code = dma ? (r.is_write ? CMD_WRITE_DMA : CMD_READ_DMA)
                               : (r.is_write ? CMD_WRITE_PIO : CMD_READ_PIO);
      return tf;
   endfunction

   task automatic check_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Sample both channels at the rising edge: check the result word against the oldest
   // expectation, then queue the expectation for a request word accepted at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (task_file_queue.size() == 0) begin
               $display("%0t: result word with no request pending, actual %h", $time,
                        {rsp_if.command_code, rsp_if.device_select, rsp_if.count_value,
                         rsp_if.address_byte0, rsp_if.address_byte1, rsp_if.address_byte2,
                         rsp_if.address_byte3, rsp_if.address_mode});
               mismatch_count++;
            end else begin
               exp_tf = task_file_queue.pop_front();
               check_field("command_code",  exp_tf.command_code,  rsp_if.command_code);
               check_field("device_select", exp_tf.device_select, rsp_if.device_select);
               check_field("count_value",   exp_tf.count_value,   rsp_if.count_value);
               check_field("address_byte0", exp_tf.address_byte0, rsp_if.address_byte0);
               check_field("address_byte1", exp_tf.address_byte1, rsp_if.address_byte1);
               check_field("address_byte2", exp_tf.address_byte2, rsp_if.address_byte2);
               check_field("address_byte3", exp_tf.address_byte3, rsp_if.address_byte3);
               check_field("address_mode",  {6'b0, exp_tf.address_mode},
                           {6'b0, rsp_if.address_mode});
            end
         end
         if (req_if.valid && req_if.ready) begin
            if (cur_fixed)
               exp_tf = cur_tf;
            else
               exp_tf = build_task_file({req_if.block_address, req_if.is_write,
                                         req_if.drive_select, req_if.sector_count,
                                         req_if.lba_capable}, dma_cfg);
            task_file_queue.push_back(exp_tf);
            mode_count[exp_tf.address_mode]++;
            dma_words[dma_cfg]++;
         end
      end
   end

   // Watchdog: end the run if no word and no register access moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (psel && penable) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still pending", $time,
                  task_file_queue.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver: drop ready at random, at the rate the current phase asks for
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic add_row(bit dma, req_word_type req, bit has_fixed, rsp_word_type tf);
      stim_row_type row;
      row.dma       = dma;
      row.req       = req;
      row.has_fixed = has_fixed;
      row.tf        = tf;
      stim_rows.push_back(row);
   endtask

   // Offer one request word and hold it until accepted; enter and leave at a falling edge
   task automatic send_word(req_word_type w, bit fixed, rsp_word_type tf);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid         = 1'b0;
         req_if.block_address = $urandom;
         @(negedge clock);
      end
      req_if.valid         = 1'b1;
      req_if.block_address = w.block_address;
      req_if.is_write      = w.is_write;
      req_if.drive_select  = w.drive_select;
      req_if.sector_count  = w.sector_count;
      req_if.lba_capable   = w.lba_capable;
      cur_fixed            = fixed;
      cur_tf               = tf;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop sending and wait for every expected task file to come back
   task automatic drain_results();
      req_if.valid = 1'b0;
      while (task_file_queue.size() != 0) @(negedge clock);
   endtask

   // APB write (setup, then access), followed by a read-back of dma_enable
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr[CSR_ADDR_W-1:2] == CSR_IDX_DMA_ENABLE)
         dma_cfg = data[0];
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      paddr   = DMA_ADDR;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {{(CSR_DATA_W-1){1'b0}}, dma_cfg}) begin
         $display("%0t: dma_enable read-back mismatch, expected %h actual %h", $time,
                  {{(CSR_DATA_W-1){1'b0}}, dma_cfg}, prdata);
         mismatch_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // Set dma_enable with random junk in the unused upper bits
   task automatic set_dma(bit value);
      csr_write(DMA_ADDR, ($urandom & 32'hFFFF_FFFE) | {31'b0, value});
   endtask

   initial begin
      int                p;
      int                n;
      req_word_type      rnd_req;
      logic [ADDR_W-1:0] addr;
      int                phase_sender[4];
      int                phase_receiver[4];
      bit                phase_dma[4];

      // Drive every input to a known value from time zero
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_if.valid         = 1'b0;
      req_if.block_address = '0;
      req_if.is_write      = 1'b0;
      req_if.drive_select  = 1'b0;
      req_if.sector_count  = '0;
      req_if.lba_capable   = 1'b0;
      dma_cfg              = 1'b0;
      cur_fixed            = 1'b0;
      cur_tf               = '0;
      mismatch_count       = 0;
      results_seen         = 0;
      quiet_cycles         = 0;
      sender_idle_pct      = 0;
      receiver_stall_pct   = 0;
      mode_count           = '{0, 0, 0};
      dma_words            = '{0, 0};

      // Directed table: {address, write, drive, count, lba_capable}; fixed expectations
      // are {opcode, devsel, count, byte0..byte3, mode}.
      // Reset state: PIO opcodes, both address modes at zero
      add_row(0, {32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b1}, 1,
              {CMD_READ_PIO, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODE_LBA28});
      add_row(0, {32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b0}, 1,
              {CMD_READ_PIO, 8'hA0, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, MODE_CHS});
      // Top of LBA28: head nibble all ones, slave, full count
      add_row(0, {32'h0FFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b1}, 1,
              {CMD_WRITE_PIO, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, MODE_LBA28});
      // LBA48 even without LBA capability; head forced to zero
      add_row(0, {32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b0}, 1,
              {CMD_WRITE_PIO_EXT, 8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, MODE_LBA48});
      add_row(0, {32'h1000_0000, 1'b0, 1'b0, 8'h01, 1'b0}, 1,
              {CMD_READ_PIO_EXT, 8'hE0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h10, MODE_LBA48});
      add_row(0, {32'h1000_0000, 1'b0, 1'b1, 8'h02, 1'b1}, 1,
              {CMD_READ_PIO_EXT, 8'hF0, 8'h02, 8'h00, 8'h00, 8'h00, 8'h10, MODE_LBA48});
      // CHS track, head and cylinder boundaries
      add_row(0, {32'd62, 1'b0, 1'b0, 8'h03, 1'b0}, 1,
              {CMD_READ_PIO, 8'hA0, 8'h03, 8'h3F, 8'h00, 8'h00, 8'h00, MODE_CHS});
      add_row(0, {32'd63, 1'b1, 1'b0, 8'h04, 1'b0}, 1,
              {CMD_WRITE_PIO, 8'hA1, 8'h04, 8'h01, 8'h00, 8'h00, 8'h00, MODE_CHS});
      add_row(0, {32'd1007, 1'b0, 1'b1, 8'h05, 1'b0}, 1,
              {CMD_READ_PIO, 8'hBF, 8'h05, 8'h3F, 8'h00, 8'h00, 8'h00, MODE_CHS});
      add_row(0, {32'd1008, 1'b0, 1'b0, 8'h06, 1'b0}, 1,
              {CMD_READ_PIO, 8'hA0, 8'h06, 8'h01, 8'h01, 8'h00, 8'h00, MODE_CHS});
      // Cylinder wrap: top of LBA28 space, last cylinder before wrap, first after
      add_row(0, {32'h0FFF_FFFF, 1'b0, 1'b0, 8'h07, 1'b0}, 0, '0);
      add_row(0, {32'd66060287, 1'b1, 1'b1, 8'h08, 1'b0}, 0, '0);
      add_row(0, {32'd66060288, 1'b0, 1'b0, 8'h09, 1'b0}, 0, '0);
      add_row(0, {32'h0ABC_DEF1, 1'b1, 1'b0, 8'h5A, 1'b1}, 0, '0);
      // DMA opcodes in every mode
      add_row(1, {32'h0000_0000, 1'b0, 1'b0, 8'h00, 1'b1}, 1,
              {CMD_READ_DMA, 8'hE0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MODE_LBA28});
      add_row(1, {32'h0FFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b1}, 1,
              {CMD_WRITE_DMA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, MODE_LBA28});
      add_row(1, {32'hFFFF_FFFF, 1'b0, 1'b0, 8'hFF, 1'b1}, 1,
              {CMD_READ_DMA_EXT, 8'hE0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, MODE_LBA48});
      add_row(1, {32'h1000_0000, 1'b1, 1'b1, 8'h80, 1'b0}, 1,
              {CMD_WRITE_DMA_EXT, 8'hF0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h10, MODE_LBA48});
      add_row(1, {32'd63, 1'b1, 1'b1, 8'h10, 1'b0}, 1,
              {CMD_WRITE_DMA, 8'hB1, 8'h10, 8'h01, 8'h00, 8'h00, 8'h00, MODE_CHS});
      add_row(1, {32'h1234_5678, 1'b0, 1'b1, 8'h33, 1'b0}, 0, '0);

      // Hold reset, then release it at a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Write dma_enable once at reset value, then hit the unused index: it must not stick
      set_dma(1'b0);
      csr_write(SPARE_ADDR, 32'hFFFF_FFFF);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].dma != dma_cfg) begin
            drain_results();
            set_dma(stim_rows[i].dma);
         end
         send_word(stim_rows[i].req, stim_rows[i].has_fixed, stim_rows[i].tf);
      end

      // Random phases: no idling, sender idle, receiver stalling, both idling lightly
      phase_sender   = '{0, 67, 0, 11};
      phase_receiver = '{0, 0, 67, 11};
      phase_dma      = '{0, 1, 0, 1};
      for (p = 0; p < 4; p++) begin
         drain_results();
         set_dma(phase_dma[p]);
         sender_idle_pct    = phase_sender[p];
         receiver_stall_pct = phase_receiver[p];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // In the receiver-stalling phase, pause mid-phase until the pipeline is empty, then resume
            if (n == PHASE_ITEMS / 2 && p == 2)
               drain_results();
            case ($urandom_range(0, 5))
               0: addr = $urandom;
               1: addr = $urandom_range(0, 32'h0FFF_FFFF);
               2: addr = 32'h0FFF_FFF0 + $urandom_range(0, 31);
               3: addr = $urandom_range(0, 2047);
               4: addr = 32'd66058240 + $urandom_range(0, 4095);
               default: addr = 32'd1008 * $urandom_range(0, 266305) - $urandom_range(0, 1);
            endcase
            rnd_req.block_address = addr;
            rnd_req.is_write      = $urandom_range(0, 1);
            rnd_req.drive_select  = $urandom_range(0, 1);
            rnd_req.sector_count  = $urandom_range(0, 255);
            rnd_req.lba_capable   = $urandom_range(0, 1);
            send_word(rnd_req, 1'b0, '0);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d task files: %0d CHS, %0d LBA28, %0d LBA48", results_seen,
               mode_count[MODE_CHS], mode_count[MODE_LBA28], mode_count[MODE_LBA48]);
      $display("PIO words %0d, DMA words %0d, four idle patterns, %0d mismatches",
               dma_words[0], dma_words[1], mismatch_count);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
